// ===== rtl/esc_pkg.sv =====
// constants and helpers for the epoch seconds to calendar converter
// no dependencies; imported by epoch_seconds_to_calendar_core
package esc_pkg;

    // seconds per day is 128 * 675, the factor 675 is done by reciprocal
    localparam int unsigned DAY_SHIFT       = 7;
    localparam logic [9:0]  DAY_DIV         = 10'd675;
    localparam logic [25:0] DAY_RECIP       = 26'd50903317;
    localparam int unsigned DAY_RECIP_SHIFT = 35;

    localparam logic [8:0]  DAYS_PER_YEAR    = 9'd365;
    localparam logic [16:0] YEAR_RECIP       = 17'd91930;
    localparam int unsigned YEAR_RECIP_SHIFT = 25;

    localparam logic [2:0]  DAYS_PER_WEEK    = 3'd7;
    localparam logic [16:0] WEEK_RECIP       = 17'd74899;
    localparam int unsigned WEEK_RECIP_SHIFT = 19;
    localparam logic [16:0] EPOCH_WEEKDAY    = 17'd4;

    // seconds per hour is 16 * 225
    localparam logic [13:0] HOUR_RECIP       = 14'd9321;
    localparam int unsigned HOUR_RECIP_SHIFT = 21;
    localparam logic [11:0] SECS_PER_HOUR    = 12'd3600;

    // seconds per minute is 4 * 15
    localparam logic [10:0] MIN_RECIP        = 11'd1093;
    localparam int unsigned MIN_RECIP_SHIFT  = 14;
    localparam logic [5:0]  SECS_PER_MIN     = 6'd60;

    // year offsets from 1970, and 1970 as an offset from 1900
    localparam logic [7:0]  BASE_YEAR_OFFSET = 8'd70;
    localparam logic [7:0]  YEAR_2100_OFFSET = 8'd130;
    localparam logic [7:0]  AFTER_2100_OFFSET = 8'd131;
    localparam logic [1:0]  LEAP_PHASE       = 2'd2;

    localparam int unsigned NUM_MONTHS = 12;

    // first day of year (from 0) of each month
    function automatic logic [8:0] month_start(input logic [3:0] mon, input logic leap);
        logic [8:0] base;
        begin
            unique case (mon)
                4'd0:    base = 9'd0;
                4'd1:    base = 9'd31;
                4'd2:    base = 9'd59;
                4'd3:    base = 9'd90;
                4'd4:    base = 9'd120;
                4'd5:    base = 9'd151;
                4'd6:    base = 9'd181;
                4'd7:    base = 9'd212;
                4'd8:    base = 9'd243;
                4'd9:    base = 9'd273;
                4'd10:   base = 9'd304;
                4'd11:   base = 9'd334;
                default: base = 9'd0;
            endcase
            if (leap && mon >= 4'd2)
            begin
                base = base + 9'd1;
            end
            return base;
        end
    endfunction

endpackage

// ===== rtl/epoch_seconds_to_calendar_core.sv =====
// epoch seconds to gregorian date and time, seven register stages
// depends on esc_pkg for reciprocal constants and the month start table
//
//  channel | signals                                  | dir
//  --------+------------------------------------------+-----
//  time    | time_valid, time_ready, epoch_seconds    | in
//  date    | date_valid, date_ready, date/time fields | out
//
// one request per cycle while no result waits untaken at the output; the stages
// follow the chain of reciprocal multiplies (day, year, hour,
// minute) with a register after each product, plus the month compare stage
// the whole pipe holds while a result waits at the output and it is not taken
// reset clears only the stage valid bits

module epoch_seconds_to_calendar_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        time_valid,
    output logic        time_ready,
    input  logic [31:0] epoch_seconds,
    output logic        date_valid,
    input  logic        date_ready,
    output logic [7:0]  years_since_1900,
    output logic [3:0]  month_index,
    output logic [4:0]  day_of_month,
    output logic [4:0]  hour_of_day,
    output logic [5:0]  minute_of_hour,
    output logic [5:0]  second_of_minute,
    output logic [2:0]  weekday,
    output logic [8:0]  day_of_year
);
    import esc_pkg::*;

    logic en;

    // stage 1: days reciprocal product
    logic        v1_reg;
    logic [24:0] x1_reg;
    logic [6:0]  lo1_reg;
    logic [50:0] prod1_reg;
    logic [50:0] prod1_next;

    // stage 2
    logic        v2_reg;
    logic [15:0] days2;
    logic [24:0] rem_wide2;
    logic [15:0] days2_reg;
    logic [16:0] tod2_reg, tod2_next;
    logic [16:0] wv2_reg, wv2_next;
    logic [33:0] prodw2_reg, prodw2_next;
    logic [32:0] prody2_reg, prody2_next;

    // stage 3
    logic        v3_reg;
    logic [14:0] wq3;
    logic [16:0] wdiff3;
    logic [15:0] days3_reg;
    logic [7:0]  yo3_reg, yo3_next;
    logic [2:0]  wday3_reg, wday3_next;
    logic [16:0] tod3_reg;
    logic [25:0] prodh3_reg, prodh3_next;

    // stage 4
    logic        v4_reg;
    logic [5:0]  leaps4;
    logic [16:0] ystart4;
    logic [16:0] hsecs4;
    logic signed [17:0] d4_reg, d4_next;
    logic [7:0]  yo4_reg;
    logic [2:0]  wday4_reg;
    logic [4:0]  hour4_reg, hour4_next;
    logic [11:0] s4_reg, s4_next;

    // stage 5
    logic        v5_reg;
    logic        neg5;
    logic [17:0] doy_wide5;
    logic [8:0]  doy5_reg;
    logic [7:0]  yo5_reg, yo5_next;
    logic        leap5_reg, leap5_next;
    logic [2:0]  wday5_reg;
    logic [4:0]  hour5_reg;
    logic [11:0] s5_reg;
    logic [19:0] prodm5_reg, prodm5_next;

    // stage 6
    logic        v6_reg;
    logic [11:0] msecs6;
    logic [11:0] sdiff6;
    logic [8:0]  doy6_reg;
    logic [3:0]  mon6_reg, mon6_next;
    logic        leap6_reg;
    logic [7:0]  yo6_reg;
    logic [2:0]  wday6_reg;
    logic [4:0]  hour6_reg;
    logic [5:0]  min6_reg, min6_next;
    logic [5:0]  sec6_reg, sec6_next;

    // output stage
    logic        out_valid_reg;
    logic [7:0]  years_reg;
    logic [3:0]  mon_reg;
    logic [4:0]  dom_reg, dom_next;
    logic [4:0]  hour_reg;
    logic [5:0]  min_reg;
    logic [5:0]  sec_reg;
    logic [2:0]  wday_reg;
    logic [8:0]  doy_reg;

    // pipe advances unless a result sits unaccepted at the output
    assign en         = !out_valid_reg || date_ready;
    assign time_ready = en;

    // stage 1
    assign prod1_next = 51'(epoch_seconds[31:DAY_SHIFT]) * 51'(DAY_RECIP);

    // stage 2
    assign days2       = prod1_reg[50:DAY_RECIP_SHIFT];
    assign rem_wide2   = x1_reg - 25'(26'(days2) * 26'(DAY_DIV));
    assign tod2_next   = {rem_wide2[9:0], lo1_reg};
    assign wv2_next    = 17'(days2) + EPOCH_WEEKDAY;
    assign prodw2_next = 34'(wv2_next) * 34'(WEEK_RECIP);
    assign prody2_next = 33'(days2) * 33'(YEAR_RECIP);

    // stage 3
    assign yo3_next    = prody2_reg[32:YEAR_RECIP_SHIFT];
    assign wq3         = prodw2_reg[33:WEEK_RECIP_SHIFT];
    assign wdiff3      = wv2_reg - 17'(wq3 * 17'(DAYS_PER_WEEK));
    assign wday3_next  = wdiff3[2:0];
    assign prodh3_next = 26'(tod2_reg[16:4]) * 26'(HOUR_RECIP);

    // stage 4: leap days in years before this one, 2100 is not leap
    assign leaps4     = 6'((9'(yo3_reg) + 9'd1) >> 2)
                        - 6'(yo3_reg >= AFTER_2100_OFFSET);
    assign ystart4    = 17'(yo3_reg) * 17'(DAYS_PER_YEAR) + 17'(leaps4);
    assign d4_next    = $signed({2'b00, days3_reg}) - $signed({1'b0, ystart4});
    assign hour4_next = prodh3_reg[25:HOUR_RECIP_SHIFT];
    assign hsecs4     = 17'(hour4_next) * 17'(SECS_PER_HOUR);
    assign s4_next    = 12'(tod3_reg - hsecs4);

    // stage 5: one step back when the year guess was late
    assign neg5        = d4_reg[17];
    assign yo5_next    = neg5 ? (yo4_reg - 8'd1) : yo4_reg;
    assign leap5_next  = (yo5_next[1:0] == LEAP_PHASE) && (yo5_next != YEAR_2100_OFFSET);
    assign doy_wide5   = neg5 ? (18'(d4_reg) + 18'(DAYS_PER_YEAR) + 18'(leap5_next))
                              : 18'(d4_reg);
    assign prodm5_next = 20'(s4_reg[11:2]) * 20'(MIN_RECIP);

    // stage 6
    assign min6_next = prodm5_reg[19:MIN_RECIP_SHIFT];
    assign msecs6    = 12'(min6_next) * 12'(SECS_PER_MIN);
    assign sdiff6    = s5_reg - msecs6;
    assign sec6_next = sdiff6[5:0];

    // month is the number of month starts at or below the day of year
    always_comb
    begin
        logic [3:0] cnt;
        cnt = 4'd0;
        for (int k = 1; k < NUM_MONTHS; k++)
        begin
            cnt = cnt + 4'(doy5_reg >= month_start(4'(k), leap5_reg));
        end
        mon6_next = cnt;
    end

    // output stage
    assign dom_next = 5'(doy6_reg - month_start(mon6_reg, leap6_reg) + 9'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= time_valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            v5_reg        <= v4_reg;
            v6_reg        <= v5_reg;
            out_valid_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg     <= epoch_seconds[31:DAY_SHIFT];
            lo1_reg    <= epoch_seconds[DAY_SHIFT-1:0];
            prod1_reg  <= prod1_next;

            days2_reg  <= days2;
            tod2_reg   <= tod2_next;
            wv2_reg    <= wv2_next;
            prodw2_reg <= prodw2_next;
            prody2_reg <= prody2_next;

            days3_reg  <= days2_reg;
            yo3_reg    <= yo3_next;
            wday3_reg  <= wday3_next;
            tod3_reg   <= tod2_reg;
            prodh3_reg <= prodh3_next;

            d4_reg     <= d4_next;
            yo4_reg    <= yo3_reg;
            wday4_reg  <= wday3_reg;
            hour4_reg  <= hour4_next;
            s4_reg     <= s4_next;

            doy5_reg   <= doy_wide5[8:0];
            yo5_reg    <= yo5_next;
            leap5_reg  <= leap5_next;
            wday5_reg  <= wday4_reg;
            hour5_reg  <= hour4_reg;
            s5_reg     <= s4_reg;
            prodm5_reg <= prodm5_next;

            doy6_reg   <= doy5_reg;
            mon6_reg   <= mon6_next;
            leap6_reg  <= leap5_reg;
            yo6_reg    <= yo5_reg;
            wday6_reg  <= wday5_reg;
            hour6_reg  <= hour5_reg;
            min6_reg   <= min6_next;
            sec6_reg   <= sec6_next;

            years_reg  <= yo6_reg + BASE_YEAR_OFFSET;
            mon_reg    <= mon6_reg;
            dom_reg    <= dom_next;
            hour_reg   <= hour6_reg;
            min_reg    <= min6_reg;
            sec_reg    <= sec6_reg;
            wday_reg   <= wday6_reg;
            doy_reg    <= doy6_reg + 9'd1;
        end
    end

    assign date_valid       = out_valid_reg;
    assign years_since_1900 = years_reg;
    assign month_index      = mon_reg;
    assign day_of_month     = dom_reg;
    assign hour_of_day      = hour_reg;
    assign minute_of_hour   = min_reg;
    assign second_of_minute = sec_reg;
    assign weekday          = wday_reg;
    assign day_of_year      = doy_reg;

`ifndef SYNTH
    // a waiting result must hold the whole pipe
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (date_valid && !date_ready) |-> !time_ready)
        else $error("request taken while result stalled");

    // year guess is never more than one year late
    a_year_guess: assert property (@(posedge clk) disable iff (!rst_n)
        v4_reg |-> (d4_reg >= -18'sd366 && d4_reg <= 18'sd364))
        else $error("day of year estimate out of range");

    // corrected day of year fits the year found
    a_doy_fits: assert property (@(posedge clk) disable iff (!rst_n)
        v5_reg |-> (doy5_reg <= 9'd364 || (leap5_reg && doy5_reg == 9'd365)))
        else $error("day of year past end of year");

    a_date_fields: assert property (@(posedge clk) disable iff (!rst_n)
        date_valid |-> (month_index <= 4'd11 && day_of_month != 5'd0
                        && weekday <= 3'd6 && hour_of_day <= 5'd23))
        else $error("result field out of range");
`endif

endmodule

// ===== sim/epoch_seconds_to_calendar_core_tb.sv =====
// self-checking testbench for epoch_seconds_to_calendar_core
// needs only the core and esc_pkg; a queue-fed driver, a random receiver and
// a monitor compare each date against an in-bench calendar predictor

module epoch_seconds_to_calendar_core_tb;

    localparam int CYCLE_LIMIT = 200000;
    localparam int SECS_DAY    = 86400;
    localparam int MAX_REPORTS = 10;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [7:0] year_off;
        logic [3:0] month;
        logic [4:0] mday;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [2:0] wday;
        logic [8:0] yday;
    } date_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        time_valid = 1'b0;
    logic        time_ready;
    logic [31:0] epoch_seconds = '0;
    logic        date_valid;
    logic        date_ready = 1'b0;
    logic [7:0]  years_since_1900;
    logic [3:0]  month_index;
    logic [4:0]  day_of_month;
    logic [4:0]  hour_of_day;
    logic [5:0]  minute_of_hour;
    logic [5:0]  second_of_minute;
    logic [2:0]  weekday;
    logic [8:0]  day_of_year;

    logic [31:0] pending_secs[$];
    date_t       pending_dates[$];

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  req_taken = 1'b0;
    bit  hold_start = 1'b0;
    bit  hold_used = 1'b0;
    int  hold_left = 0;
    int  cycle_count = 0;
    int  dates_checked = 0;
    int  mismatches = 0;
    int  backpressure_cycles = 0;

    epoch_seconds_to_calendar_core dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .time_valid       (time_valid),
        .time_ready       (time_ready),
        .epoch_seconds    (epoch_seconds),
        .date_valid       (date_valid),
        .date_ready       (date_ready),
        .years_since_1900 (years_since_1900),
        .month_index      (month_index),
        .day_of_month     (day_of_month),
        .hour_of_day      (hour_of_day),
        .minute_of_hour   (minute_of_hour),
        .second_of_minute (second_of_minute),
        .weekday          (weekday),
        .day_of_year      (day_of_year)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic bit yr_is_leap(input int yr);
        return ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
    endfunction

    // leap days from year 1 through yr
    function automatic int leaps_through(input int yr);
        return yr / 4 - yr / 100 + yr / 400;
    endfunction

    function automatic int mon_length(input int mon, input bit leap);
        case (mon)
            1:          return leap ? 29 : 28;
            3, 5, 8, 10: return 30;
            default:    return 31;
        endcase
    endfunction

    function automatic date_t calendar_of(input logic [31:0] secs);
        int    day_count;
        int    tod;
        int    yr;
        int    rem_days;
        int    mon_no;
        bit    leap;
        date_t d;
        day_count = int'(secs / SECS_DAY);
        tod       = int'(secs % SECS_DAY);
        d.wday    = 3'((day_count + 4) % 7);
        // estimate by 365-day years runs at most one year late
        yr        = 1970 + day_count / 365;
        rem_days  = day_count - ((yr - 1970) * 365 + leaps_through(yr - 1)
                    - leaps_through(1969));
        if (rem_days < 0)
        begin
            yr       = yr - 1;
            rem_days = rem_days + (yr_is_leap(yr) ? 366 : 365);
        end
        leap   = yr_is_leap(yr);
        d.yday = 9'(rem_days + 1);
        mon_no = 0;
        while (mon_no < 11 && rem_days >= mon_length(mon_no, leap))
        begin
            rem_days = rem_days - mon_length(mon_no, leap);
            mon_no   = mon_no + 1;
        end
        d.year_off = 8'(yr - 1900);
        d.month    = 4'(mon_no);
        d.mday     = 5'(rem_days + 1);
        d.hour     = 5'(tod / 3600);
        d.minute   = 6'((tod % 3600) / 60);
        d.second   = 6'(tod % 60);
        return d;
    endfunction

    function automatic string date_text(input date_t d);
        return $sformatf("%0d-%0d-%0d %0d:%0d:%0d wd=%0d yd=%0d",
                         d.year_off + 1900, d.month + 1, d.mday,
                         d.hour, d.minute, d.second, d.wday, d.yday);
    endfunction

    // random seconds: full range, day edges, and year/leap-day edges
    task automatic queue_random(input int count);
        logic [63:0] wide;
        int          pick;
        int          yr;
        int          offs;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 9);
            offs = $urandom_range(0, 2);
            if (pick < 5)
            begin
                wide = 64'($urandom);
            end
            else if (pick < 8)
            begin
                wide = 64'($urandom_range(0, 49710)) * SECS_DAY;
                wide = $urandom_range(0, 1) ? wide + offs : wide - 1 - offs;
            end
            else
            begin
                yr   = $urandom_range(1970, 2106);
                wide = 64'((yr - 1970) * 365 + leaps_through(yr - 1) - leaps_through(1969));
                // jan 1, feb 29 (mar 1 when the year has none) or day 118 of the year
                wide = (wide + $urandom_range(0, 2) * 59) * SECS_DAY;
                wide = $urandom_range(0, 1) ? wide + offs : wide - 1 - offs;
            end
            pending_secs.push_back(wide[31:0]);
        end
    endtask

    task automatic wait_drained();
        while (pending_secs.size() != 0 || time_valid || pending_dates.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    // driver: next request goes out at the falling edge once the last one is taken
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            time_valid <= 1'b0;
        end
        else if (!time_valid || req_taken)
        begin
            if (pending_secs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                time_valid    <= 1'b1;
                epoch_seconds <= pending_secs.pop_front();
            end
            else
            begin
                time_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls, plus one long hold-off counted here
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            date_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left  = hold_left - 1;
            date_ready <= 1'b0;
        end
        else if (hold_start && !hold_used)
        begin
            hold_used  = 1'b1;
            hold_left  = HOLD_CYCLES;
            date_ready <= 1'b0;
        end
        else
        begin
            date_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // monitor: records accepted requests and checks each result in order
    always @(posedge clk)
    begin : monitor
        date_t want;
        date_t got;
        cycle_count = cycle_count + 1;
        req_taken   = rst_n && time_valid && time_ready;
        if (req_taken)
        begin
            pending_dates.push_back(calendar_of(epoch_seconds));
        end
        if (rst_n && time_valid && !time_ready)
        begin
            backpressure_cycles = backpressure_cycles + 1;
        end
        if (rst_n && date_valid && date_ready)
        begin
            got = '{years_since_1900, month_index, day_of_month, hour_of_day,
                    minute_of_hour, second_of_minute, weekday, day_of_year};
            if (pending_dates.size() == 0)
            begin
                mismatches = mismatches + 1;
                if (mismatches <= MAX_REPORTS)
                begin
                    $display("unexpected date with nothing pending: %s", date_text(got));
                end
            end
            else
            begin
                want = pending_dates.pop_front();
                dates_checked = dates_checked + 1;
                if (got !== want)
                begin
                    mismatches = mismatches + 1;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("date mismatch at cycle %0d: expected %s, got %s",
                                 cycle_count, date_text(want), date_text(got));
                    end
                end
            end
        end
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d dates still pending",
                     cycle_count, pending_dates.size());
            $display("epoch_seconds_to_calendar_core_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, day and year edges, century leap rule
        pending_secs.push_back(32'd0);
        pending_secs.push_back(32'd1);
        pending_secs.push_back(32'd59);
        pending_secs.push_back(32'd60);
        pending_secs.push_back(32'd3599);
        pending_secs.push_back(32'd3600);
        pending_secs.push_back(32'd86399);
        pending_secs.push_back(32'd86400);
        pending_secs.push_back(32'd68169600);     // 1972 leap day
        pending_secs.push_back(32'd94694399);     // last second of 1972, year estimate late
        pending_secs.push_back(32'd94694400);
        pending_secs.push_back(32'd946684799);    // end of 1999
        pending_secs.push_back(32'd946684800);
        pending_secs.push_back(32'd951868799);    // end of 2000 leap day
        pending_secs.push_back(32'd951868800);
        pending_secs.push_back(32'd4107542399);   // 2100 has no leap day
        pending_secs.push_back(32'd4107542400);
        pending_secs.push_back(32'd4291747199);   // last second of 2105
        pending_secs.push_back(32'd4291747200);
        pending_secs.push_back(32'h7FFF_FFFF);
        pending_secs.push_back(32'h8000_0000);
        pending_secs.push_back(32'h5555_5555);
        pending_secs.push_back(32'hAAAA_AAAA);
        pending_secs.push_back(32'hFFFF_FFFE);
        pending_secs.push_back(32'hFFFF_FFFF);
        queue_random(90);
        wait_drained();

        send_idle_pct  = 86;
        recv_stall_pct = 0;
        queue_random(100);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 86;
        queue_random(100);
        wait_drained();

        send_idle_pct  = 21;
        recv_stall_pct = 21;
        queue_random(100);
        wait_drained();

        // long output hold-off while requests keep coming
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_start     = 1'b1;
        queue_random(60);
        wait_drained();

        repeat (20) @(posedge clk);
        $display("checked %0d dates over burst, sparse-input, stalled-output and mixed phases",
                 dates_checked);
        $display("input was held off for %0d cycles by output backpressure",
                 backpressure_cycles);
        if (mismatches == 0 && pending_dates.size() == 0)
        begin
            $display("epoch_seconds_to_calendar_core_tb: done, clean");
        end
        else
        begin
            $display("%0d mismatches, %0d dates never arrived", mismatches, pending_dates.size());
            $display("epoch_seconds_to_calendar_core_tb: done, errors");
        end
        $finish;
    end

endmodule
